[src/bfpa_pkg.sv]
package bfpa_pkg;

  localparam int FREE_ENTRIES_DEF = 16;
  localparam int USED_ENTRIES_DEF = 16;
  localparam logic [15:0] TOTAL_RESET = 16'd1024;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] request_size;
    logic [15:0] process_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] start_address;
    logic [15:0] assigned_id;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the item, clear scan results
    logic scan;      // examine entry at scan index
    logic commit;    // apply the update
    logic respond;   // drive the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

[src/bfpa_ctrl.sv]
module bfpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bfpa_pkg::dp_stat_t stat,
  output bfpa_pkg::dp_cmd_t  cmd
);
  import bfpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

[src/bfpa_dp.sv]
module bfpa_dp #(
  parameter int FREE_ENTRIES = bfpa_pkg::FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = bfpa_pkg::USED_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  bfpa_pkg::in_item_t  in_item,
  input  bfpa_pkg::dp_cmd_t   cmd,
  output bfpa_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output bfpa_pkg::out_item_t out_item
);
  import bfpa_pkg::*;

  localparam int FW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int UW = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
  localparam int MAXN = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int SW = $clog2(MAXN + 1);

  logic [15:0] fs_r [FREE_ENTRIES];
  logic [16:0] fl_r [FREE_ENTRIES];
  logic [FREE_ENTRIES-1:0] fv_r;
  logic [15:0] uo_r [USED_ENTRIES];
  logic [15:0] us_r [USED_ENTRIES];
  logic [16:0] ul_r [USED_ENTRIES];
  logic [USED_ENTRIES-1:0] uv_r;
  logic [15:0] next_id_r;

  in_item_t item_r;
  logic [SW-1:0] idx_r;
  // best fit / free slot
  logic          best_ok_r;
  logic [FW-1:0] best_r;
  logic [16:0]   best_len_r;
  logic [15:0]   best_start_r;
  logic          fslot_ok_r;
  logic [FW-1:0] fslot_r;
  // used slot / hit
  logic          uslot_ok_r;
  logic [UW-1:0] uslot_r;
  logic          hit_ok_r;
  logic [UW-1:0] hit_r;

  out_item_t res_r;
  logic      ovalid_r;

  assign stat.scan_last = (idx_r == SW'(MAXN - 1));
  assign out_valid = ovalid_r;
  assign out_item  = res_r;

  logic [FW-1:0] fi;
  logic [UW-1:0] ui;
  logic f_in, u_in;
  assign fi = idx_r[FW-1:0];
  assign ui = idx_r[UW-1:0];
  assign f_in = (idx_r < SW'(FREE_ENTRIES));
  assign u_in = (idx_r < SW'(USED_ENTRIES));

  logic [16:0] req17;
  assign req17 = {1'b0, item_r.request_size};
  logic [16:0] rem;
  assign rem = best_len_r - req17;
  logic [15:0] nid;
  assign nid = next_id_r + 16'd1;

  always_ff @(posedge clk) begin
    ovalid_r <= 1'b0;
    if (cmd.load) begin
      item_r <= in_item;
      idx_r <= '0;
      best_ok_r <= 1'b0;
      fslot_ok_r <= 1'b0;
      uslot_ok_r <= 1'b0;
      hit_ok_r <= 1'b0;
      best_r <= '0;
      best_len_r <= '0;
      best_start_r <= '0;
      fslot_r <= '0;
      uslot_r <= '0;
      hit_r <= '0;
    end
    if (cmd.scan) begin
      idx_r <= idx_r + SW'(1);
      if (f_in) begin
        if (fv_r[fi] && fl_r[fi] >= req17 &&
            (!best_ok_r || fl_r[fi] < best_len_r ||
             (fl_r[fi] == best_len_r && fs_r[fi] < best_start_r))) begin
          best_ok_r <= 1'b1;
          best_r <= fi;
          best_len_r <= fl_r[fi];
          best_start_r <= fs_r[fi];
        end
        if (!fv_r[fi] && !fslot_ok_r) begin
          fslot_ok_r <= 1'b1;
          fslot_r <= fi;
        end
      end
      if (u_in) begin
        if (!uv_r[ui] && !uslot_ok_r) begin
          uslot_ok_r <= 1'b1;
          uslot_r <= ui;
        end
        if (uv_r[ui] && uo_r[ui] == item_r.process_id && !hit_ok_r) begin
          hit_ok_r <= 1'b1;
          hit_r <= ui;
        end
      end
    end
    if (cmd.commit) begin
      res_r <= '0;
      if (item_r.cmd == CMD_ALLOC) begin
        if (item_r.request_size == 16'd0 || !best_ok_r) res_r.status <= ST_NOFIT;
        else if (!uslot_ok_r) res_r.status <= ST_FULL;
        else begin
          res_r.status <= ST_OK;
          res_r.start_address <= best_start_r;
          res_r.assigned_id <= nid;
          next_id_r <= nid;
          uo_r[uslot_r] <= nid;
          us_r[uslot_r] <= best_start_r;
          ul_r[uslot_r] <= req17;
          uv_r[uslot_r] <= 1'b1;
          fs_r[best_r] <= best_start_r + item_r.request_size;
          fl_r[best_r] <= rem;
          if (rem <= 17'd1) fv_r[best_r] <= 1'b0;
        end
      end else begin
        if (!hit_ok_r) res_r.status <= ST_UNKNOWN;
        else if (!fslot_ok_r) res_r.status <= ST_FULL;
        else begin
          res_r.status <= ST_OK;
          res_r.start_address <= us_r[hit_r];
          fs_r[fslot_r] <= us_r[hit_r];
          fl_r[fslot_r] <= ul_r[hit_r];
          fv_r[fslot_r] <= 1'b1;
          uv_r[hit_r] <= 1'b0;
        end
      end
    end
    if (cmd.respond) ovalid_r <= 1'b1;
    // reload of the free table on a size write
    if (cfg_we) begin
      fv_r <= FREE_ENTRIES'(1);
      fs_r[0] <= '0;
      fl_r[0] <= {1'b0, cfg_wdata};
    end
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      fv_r <= FREE_ENTRIES'(1);
      fs_r[0] <= '0;
      fl_r[0] <= {1'b0, TOTAL_RESET};
      uv_r <= '0;
      next_id_r <= '0;
      idx_r <= '0;
    end
  end
endmodule

[src/best_fit_partition_allocator_top.sv]
// best-fit partition allocator: one result item per input item
// throughput: one item at a time; busy is high through the entry-by-entry table scan,
//   commit and respond; the receiver cannot stall, results last one cycle
// reset: synchronous active-low rst_n; free table holds one block of 1024 units
module best_fit_partition_allocator_top #(
  parameter int FREE_ENTRIES = bfpa_pkg::FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = bfpa_pkg::USED_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bfpa_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bfpa_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import bfpa_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // sequencer: idle, scan every table entry, commit, respond
  bfpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dstat),
    .cmd   (dcmd)
  );

  // tables, best-fit tracking and result register
  bfpa_dp #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .USED_ENTRIES (USED_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (dcmd),
    .stat      (dstat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );
endmodule

[tb/best_fit_partition_allocator_top_test.sv]
module best_fit_partition_allocator_top_test;
  import bfpa_pkg::*;

  localparam int NFREE = FREE_ENTRIES_DEF;
  localparam int NUSED = USED_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 400000;

  // one row of the directed table; has_exp marks rows whose answer is typed in
  typedef struct {
    logic      cmd;
    int        size;
    int        pid;
    bit        has_exp;
    out_item_t exp;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int cycle_count = 0;
  int error_count = 0;

  // predictor state
  logic [15:0] pool_size;
  logic [15:0] hole_start [NFREE];
  logic [16:0] hole_len [NFREE];
  bit          hole_live [NFREE];
  logic [15:0] blk_owner [NUSED];
  logic [15:0] blk_start [NUSED];
  logic [16:0] blk_len [NUSED];
  bit          blk_live [NUSED];
  logic [15:0] last_owner;

  out_item_t pending_answers [$];
  step_row_t plan [$];

  best_fit_partition_allocator_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("best_fit_partition_allocator_top test failed");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // reload the hole table with one block spanning the pool
  function automatic void reload_holes(input logic [15:0] total);
    pool_size = total;
    for (int i = 0; i < NFREE; i++) begin
      hole_start[i] = '0;
      hole_len[i] = '0;
      hole_live[i] = 0;
    end
    hole_len[0] = {1'b0, total};
    hole_live[0] = 1;
  endfunction

  function automatic out_item_t predict_grant(input logic cmd, input logic [15:0] size,
                                              input logic [15:0] pid);
    out_item_t r;
    int best;
    int slot;
    best = -1;
    slot = -1;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_ALLOC) begin
      if (size == 0) begin
        r.status = ST_NOFIT;
        return r;
      end
      for (int i = 0; i < NFREE; i++) begin
        if (!hole_live[i] || hole_len[i] < size) continue;
        if (best < 0 || hole_len[i] < hole_len[best] ||
            (hole_len[i] == hole_len[best] && hole_start[i] < hole_start[best]))
          best = i;
      end
      if (best < 0) begin
        r.status = ST_NOFIT;
        return r;
      end
      for (int i = 0; i < NUSED; i++)
        if (!blk_live[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        r.status = ST_FULL;
        return r;
      end
      last_owner = last_owner + 16'd1;
      blk_owner[slot] = last_owner;
      blk_start[slot] = hole_start[best];
      blk_len[slot] = {1'b0, size};
      blk_live[slot] = 1;
      r.start_address = hole_start[best];
      r.assigned_id = last_owner;
      hole_start[best] = hole_start[best] + size;
      hole_len[best] = hole_len[best] - size;
      if (hole_len[best] <= 1) hole_live[best] = 0;
    end else begin
      for (int i = 0; i < NUSED; i++)
        if (blk_live[i] && blk_owner[i] == pid) begin
          best = i;
          break;
        end
      if (best < 0) begin
        r.status = ST_UNKNOWN;
        return r;
      end
      for (int i = 0; i < NFREE; i++)
        if (!hole_live[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        r.status = ST_FULL;
        return r;
      end
      hole_start[slot] = blk_start[best];
      hole_len[slot] = blk_len[best];
      hole_live[slot] = 1;
      blk_live[best] = 0;
      r.start_address = blk_start[best];
    end
    return r;
  endfunction

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        report("unexpected result items", 1, 0);
      end else begin
        out_item_t w;
        w = pending_answers.pop_front();
        if (out_item.status !== w.status) report("status", out_item.status, w.status);
        if (out_item.start_address !== w.start_address)
          report("start_address", out_item.start_address, w.start_address);
        if (out_item.assigned_id !== w.assigned_id)
          report("assigned_id", out_item.assigned_id, w.assigned_id);
      end
    end
  end

  // issue one item, waiting for the block to be free
  task automatic send_item(input logic cmd, input logic [15:0] size, input logic [15:0] pid,
                           input bit has_exp, input out_item_t exp);
    out_item_t p;
    @(negedge clk);
    in_item.cmd <= cmd;
    in_item.request_size <= size;
    in_item.process_id <= pid;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    p = predict_grant(cmd, size, pid);
    if (has_exp) begin
      if (p.status !== exp.status) report("directed status", p.status, exp.status);
      if (p.start_address !== exp.start_address)
        report("directed start_address", p.start_address, exp.start_address);
      if (p.assigned_id !== exp.assigned_id)
        report("directed assigned_id", p.assigned_id, exp.assigned_id);
    end
    pending_answers.push_back(p);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_pool(input logic [15:0] total);
    drain();
    cfg_wdata <= total;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    reload_holes(total);
  endtask

  function automatic out_item_t mk(input status_t s, input int a, input int id);
    out_item_t r;
    r.status = s;
    r.start_address = a[15:0];
    r.assigned_id = id[15:0];
    return r;
  endfunction

  function automatic step_row_t row(input logic cmd, input int size, input int pid,
                                    input bit has_exp, input out_item_t exp);
    step_row_t r;
    r.cmd = cmd;
    r.size = size;
    r.pid = pid;
    r.has_exp = has_exp;
    r.exp = exp;
    return r;
  endfunction

  // random phase: allocs of mostly small sizes, frees of mostly recent owner ids
  task automatic random_phase(input int count);
    int gap;
    int burst;
    logic cmd;
    logic [15:0] size;
    logic [15:0] pid;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
        repeat (gap) @(negedge clk);
      end
      burst--;
      cmd = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: size = 16'($urandom);
        1: size = 16'hffff;
        2: size = 16'd0;
        default: size = 16'($urandom_range(1, pool_size / 8 + 1));
      endcase
      if ($urandom_range(0, 4) == 0) pid = 16'($urandom);
      else pid = last_owner - 16'($urandom_range(0, 20));
      send_item(cmd, size, pid, 0, '0);
    end
  endtask

  initial begin
    step_row_t r;
    reload_holes(TOTAL_RESET);
    for (int i = 0; i < NUSED; i++) blk_live[i] = 0;
    last_owner = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every status, duplicate owners, full tables
    plan.push_back(row(CMD_ALLOC, 0, 0, 1, mk(ST_NOFIT, 0, 0)));
    plan.push_back(row(CMD_ALLOC, 1025, 0, 1, mk(ST_NOFIT, 0, 0)));
    plan.push_back(row(CMD_FREE, 0, 1, 1, mk(ST_UNKNOWN, 0, 0)));
    plan.push_back(row(CMD_ALLOC, 100, 0, 1, mk(ST_OK, 0, 1)));
    plan.push_back(row(CMD_ALLOC, 200, 0, 1, mk(ST_OK, 100, 2)));
    plan.push_back(row(CMD_FREE, 16'hffff, 1, 1, mk(ST_OK, 0, 0)));
    plan.push_back(row(CMD_ALLOC, 50, 0, 0, '0));
    plan.push_back(row(CMD_FREE, 0, 16'hffff, 1, mk(ST_UNKNOWN, 0, 0)));
    plan.push_back(row(CMD_ALLOC, 723, 0, 0, '0));
    plan.push_back(row(CMD_ALLOC, 1, 0, 0, '0));
    plan.push_back(row(CMD_FREE, 0, 2, 0, '0));
    plan.push_back(row(CMD_FREE, 0, 2, 1, mk(ST_UNKNOWN, 0, 0)));
    foreach (plan[i]) begin
      r = plan[i];
      send_item(r.cmd, r.size[15:0], r.pid[15:0], r.has_exp, r.exp);
    end
    // fill the block table until it reports full
    write_pool(16'hffff);
    for (int i = 0; i < 18; i++) send_item(CMD_ALLOC, 16'd1, 16'd0, 0, '0);
    send_item(CMD_ALLOC, 16'hffff, 16'd0, 1, mk(ST_NOFIT, 0, 0));
    // free everything back so the hole table overflows
    for (int i = 0; i < 18; i++) send_item(CMD_FREE, 16'd0, last_owner - 16'(i), 0, '0);
    write_pool(16'd0);
    send_item(CMD_ALLOC, 16'd1, 16'd0, 1, mk(ST_NOFIT, 0, 0));

    // random phases across pool sizes; owners leak across reloads
    write_pool(16'd1);
    random_phase(100);
    write_pool(16'd2);
    random_phase(100);
    write_pool(TOTAL_RESET);
    random_phase(500);
    drain();
    write_pool(16'hffff);
    random_phase(500);
    write_pool(16'($urandom_range(3, 65534)));
    random_phase(400);

    drain();
    if (error_count == 0) begin
      $display("best_fit_partition_allocator_top test passed");
    end else begin
      $display("best_fit_partition_allocator_top test failed");
    end
    $finish;
  end
endmodule

[best_fit_partition_allocator_top.f]
src/bfpa_pkg.sv
src/bfpa_ctrl.sv
src/bfpa_dp.sv
src/best_fit_partition_allocator_top.sv
tb/best_fit_partition_allocator_top_test.sv
